// ===== sv/utf8_to_utf16_transcoder_assert.svh =====
// Assertion macros for the UTF-8 to UTF-16 transcoder.
`ifndef UTF8_TO_UTF16_TRANSCODER_ASSERT_SVH
`define UTF8_TO_UTF16_TRANSCODER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define UTT_ASSERT_NOW(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("utt assertion failed: same-cycle check");

// Next-cycle implication, disabled during reset.
`define UTT_ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("utt assertion failed: next-cycle check");

`endif

// ===== sv/utt_pkg.sv =====
// Shared types and constants of the UTF-8 to UTF-16 transcoder.
package utt_pkg;

  localparam int PEND_W  = 3;
  localparam int POINT_W = 31;
  localparam int UNIT_W  = 16;

  localparam logic [UNIT_W-1:0]  REPLACEMENT_UNIT = 16'hFFFD;
  localparam logic [UNIT_W-1:0]  HIGH_SURR_BASE   = 16'hD800;
  localparam logic [UNIT_W-1:0]  LOW_SURR_BASE    = 16'hDC00;
  localparam logic [POINT_W-1:0] SUPPLEMENT_BASE  = 31'h0001_0000;
  localparam logic [PEND_W-1:0]  PEND_NONE        = 3'd0;
  localparam logic [PEND_W-1:0]  PEND_MAX         = 3'd5;

  // One result item.
  typedef struct packed {
    logic [UNIT_W-1:0] unit;
    logic              run_last;
    logic              stream_end;
  } res_t;

  // All results caused by one input byte (0 to 2).
  typedef struct packed {
    logic [1:0] count;
    res_t       first;
    res_t       second;
  } res_set_t;

  typedef struct packed {
    logic [PEND_W-1:0] bytes_pending;
  } dec_status_t;

  typedef struct packed {
    logic [1:0] count;
    logic       can_load;
  } buf_status_t;

endpackage

// ===== sv/utt_decode.sv =====
// Sequence decoder: holds the partial code point and forms the units of one byte.
module utt_decode (
  input  logic                clk,
  input  logic                rst,
  input  logic                take,
  input  logic [7:0]          in_byte,
  input  logic                in_last,
  input  logic                swap,
  output utt_pkg::res_set_t   res_set,
  output utt_pkg::dec_status_t status
);
  import utt_pkg::*;

  logic [POINT_W-1:0] partial_point;
  logic [POINT_W-1:0] partial_point_next;
  logic [PEND_W-1:0]  bytes_pending;
  logic [PEND_W-1:0]  bytes_pending_next;

  logic               lead_ascii;
  logic               lead_stray;
  logic               lead_open;
  logic [PEND_W-1:0]  lead_pend;
  logic [4:0]         lead_bits;
  logic [UNIT_W-1:0]  lead_unit;
  logic               lead_emits;

  logic               in_seq;
  logic               is_cont;
  logic [POINT_W-1:0] cp;
  logic [POINT_W-1:0] cp_off;
  logic [PEND_W-1:0]  pend_dec;
  logic [UNIT_W-1:0]  hi_unit;
  logic [UNIT_W-1:0]  lo_unit;

  logic [UNIT_W-1:0]  u0;
  logic [UNIT_W-1:0]  u1;
  logic [1:0]         cnt;

  function automatic logic [UNIT_W-1:0] swap16(input logic [UNIT_W-1:0] u, input logic en);
    return en ? {u[7:0], u[15:8]} : u;
  endfunction

  // Lead byte classification
  always_comb begin
    lead_ascii = !in_byte[7];
    lead_stray = (in_byte[7:6] == 2'b10) || (in_byte[7:1] == 7'b1111111);
    lead_open  = !lead_ascii && !lead_stray;
    if (!in_byte[5]) begin
      lead_pend = 3'd1;
      lead_bits = in_byte[4:0];
    end else if (!in_byte[4]) begin
      lead_pend = 3'd2;
      lead_bits = {1'b0, in_byte[3:0]};
    end else if (!in_byte[3]) begin
      lead_pend = 3'd3;
      lead_bits = {2'b00, in_byte[2:0]};
    end else if (!in_byte[2]) begin
      lead_pend = 3'd4;
      lead_bits = {3'b000, in_byte[1:0]};
    end else begin
      lead_pend = PEND_MAX;
      lead_bits = {4'b0000, in_byte[0]};
    end
    lead_unit  = lead_ascii ? {8'h00, in_byte} : REPLACEMENT_UNIT;
    // a lead cut off by the last byte gives a replacement unit
    lead_emits = lead_ascii || lead_stray || in_last;
  end

  // Continuation path and surrogate split
  always_comb begin
    in_seq   = (bytes_pending != PEND_NONE);
    is_cont  = (in_byte[7:6] == 2'b10);
    cp       = {partial_point[POINT_W-7:0], in_byte[5:0]};
    cp_off   = cp - SUPPLEMENT_BASE;
    pend_dec = bytes_pending - 3'd1;
    hi_unit  = cp_off[25:10] | HIGH_SURR_BASE;
    lo_unit  = {6'b000000, cp_off[9:0]} | LOW_SURR_BASE;
  end

  always_comb begin
    u0                 = REPLACEMENT_UNIT;
    u1                 = REPLACEMENT_UNIT;
    cnt                = 2'd0;
    bytes_pending_next = PEND_NONE;
    partial_point_next = '0;
    if (in_seq && is_cont) begin
      if (pend_dec == PEND_NONE) begin
        if (cp[POINT_W-1:16] != '0) begin
          u0  = hi_unit;
          u1  = lo_unit;
          cnt = 2'd2;
        end else begin
          u0  = cp[15:0];
          cnt = 2'd1;
        end
      end else if (in_last) begin
        cnt = 2'd1;
      end else begin
        bytes_pending_next = pend_dec;
        partial_point_next = cp;
      end
    end else begin
      // new lead or broken sequence: replacement first if one was open, then the byte as a lead
      u0  = in_seq ? REPLACEMENT_UNIT : lead_unit;
      u1  = lead_unit;
      cnt = {1'b0, in_seq} + {1'b0, lead_emits};
      if (lead_open && !in_last) begin
        bytes_pending_next = lead_pend;
        partial_point_next = {{(POINT_W-5){1'b0}}, lead_bits};
      end
    end
  end

  always_comb begin
    res_set.count             = cnt;
    res_set.first.unit        = swap16(u0, swap);
    res_set.first.run_last    = (cnt == 2'd1);
    res_set.first.stream_end  = in_last && (cnt == 2'd1);
    res_set.second.unit       = swap16(u1, swap);
    res_set.second.run_last   = 1'b1;
    res_set.second.stream_end = in_last;
    status.bytes_pending      = bytes_pending;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_pending <= PEND_NONE;
      partial_point <= '0;
    end else if (take) begin
      bytes_pending <= bytes_pending_next;
      partial_point <= partial_point_next;
    end
  end

endmodule

// ===== sv/utt_out_buf.sv =====
// Two-entry result register that hands out one unit per cycle while m_tready is high.
module utt_out_buf (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load,
  input  utt_pkg::res_set_t    res_set,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [15:0]          m_tdata,  // out_unit[15:0]
  output logic                 m_tlast,  // run_last
  output logic                 m_tuser,  // stream_end
  output utt_pkg::buf_status_t status
);
  import utt_pkg::*;

  logic [1:0] count;
  res_t       head;
  res_t       tail;
  logic       pop;

  assign m_tvalid        = (count != 2'd0);
  assign pop             = m_tvalid && m_tready;
  assign m_tdata         = head.unit;
  assign m_tlast         = head.run_last;
  assign m_tuser         = head.stream_end;
  assign status.count    = count;
  // room for a new set once the last pending unit leaves this cycle
  assign status.can_load = (count == 2'd0) || ((count == 2'd1) && m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else if (load) begin
      count <= res_set.count;
    end else if (pop) begin
      count <= count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      head <= res_set.first;
      tail <= res_set.second;
    end else if (pop) begin
      head <= tail;
    end
  end

endmodule

// ===== sv/utf8_to_utf16_transcoder.sv =====
// Top level: UTF-8 byte stream in, UTF-16 unit stream out.
// An accepted byte passes the input register, then the result register, to m_tdata.
// Throughput: one byte per cycle while m_tready is high; a byte giving two units
// (surrogate pair or broken sequence) stalls the input, set by the one output port.
// Reset (rst, synchronous, active high) closes any open sequence, empties the
// input and result registers and clears swap_output.
`include "utf8_to_utf16_transcoder_assert.svh"

module utf8_to_utf16_transcoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,  // swap_output
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,      // in_byte[7:0]
  input  logic        s_tlast,      // last_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,      // out_unit[15:0]
  output logic        m_tlast,      // run_last
  output logic        m_tuser       // stream_end
);
  import utt_pkg::*;

  logic        swap_output;
  logic        in_valid;
  logic [7:0]  in_byte;
  logic        in_last;
  logic        advance;

  res_set_t    res_set;
  dec_status_t dec_status;
  buf_status_t buf_status;

  assign advance  = in_valid && buf_status.can_load;
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      swap_output <= 1'b0;
    end else if (cfg_wr_en) begin
      swap_output <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_byte <= s_tdata;
      in_last <= s_tlast;
    end
  end

  utt_decode u_decode (
    .clk     (clk),
    .rst     (rst),
    .take    (advance),
    .in_byte (in_byte),
    .in_last (in_last),
    .swap    (swap_output),
    .res_set (res_set),
    .status  (dec_status)
  );

  utt_out_buf u_out_buf (
    .clk      (clk),
    .rst      (rst),
    .load     (advance),
    .res_set  (res_set),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser),
    .status   (buf_status)
  );

  // a held byte stays put until the result register has room
  `UTT_ASSERT_NEXT(a_hold_item, clk, rst, in_valid && !advance, in_valid)
  // never more than five continuation bytes outstanding
  `UTT_ASSERT_NOW(a_pend_range, clk, rst, 1'b1, dec_status.bytes_pending <= PEND_MAX)
  // the last byte of a stream leaves no sequence open
  `UTT_ASSERT_NEXT(a_last_closes, clk, rst, advance && in_last,
                   dec_status.bytes_pending == PEND_NONE)
  // the result register never holds more than two units
  `UTT_ASSERT_NOW(a_buf_depth, clk, rst, m_tvalid, buf_status.count <= 2'd2)

endmodule
